>>> rtl/assert_macros.svh
// Assertion macros used by the transform unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: property failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> rtl/atu_pkg.sv
// Shared types and constants of the affine transform unit.
package atu_pkg;

    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 3;
    localparam int ROW_SEL_W = 2;

    localparam int ROWS     = 3;
    localparam int COLS     = 4;
    localparam int DOTS     = 3;
    localparam int MAT_SIZE = ROWS * COLS;
    localparam int NUM_PROD = MAT_SIZE * DOTS;

    localparam int IN_DATA_W  = 7 * FIELD_W;
    localparam int IN_USER_W  = CMD_W + ROW_SEL_W;
    localparam int OUT_DATA_W = 3 * FIELD_W;
    localparam int OUT_USER_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_CUR  = 3'd0,
        CMD_LOAD_OPD  = 3'd1,
        CMD_COMPOSE   = 3'd2,
        CMD_TRANSFORM = 3'd3,
        CMD_IDENTITY  = 3'd4
    } cmd_t;

    // Control handed from the input stage to the product stage.
    typedef struct packed {
        logic load;
        logic compose;
    } stage_ctl_t;

endpackage

>>> rtl/atu_product_stage.sv
// Multiplier array and product register of the transform unit.
module atu_product_stage
    import atu_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                                  clk,
    input  stage_ctl_t                            ctl,
    input  logic signed [COEF_BITS-1:0]           cur   [MAT_SIZE],
    input  logic signed [COEF_BITS-1:0]           opd   [MAT_SIZE],
    input  logic signed [FIELD_W-1:0]             point [ROWS],
    output logic signed [COEF_BITS+((COEF_BITS > FIELD_W) ? COEF_BITS : FIELD_W)
                         -FRAC_BITS-1:0]          prod  [NUM_PROD],
    output logic signed [COEF_BITS-1:0]           trans [ROWS]
);

    localparam int BW  = (COEF_BITS > FIELD_W) ? COEF_BITS : FIELD_W;
    localparam int FW  = COEF_BITS + BW;
    localparam int PSW = FW - FRAC_BITS;

    logic signed [PSW-1:0]       prod_next [NUM_PROD];
    logic signed [PSW-1:0]       prod_reg  [NUM_PROD];
    logic signed [COEF_BITS-1:0] trans_reg [ROWS];

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < COLS; c++)
        begin : g_col
            for (genvar k = 0; k < DOTS; k++)
            begin : g_term
                localparam int P = (r * COLS + c) * DOTS + k;
                logic signed [BW-1:0] b_op;
                logic signed [FW-1:0] full;

                // Compose takes the operand column, transform the point.
                assign b_op = ctl.compose ? BW'(opd[k * COLS + c]) : BW'(point[k]);
                assign full = cur[r * COLS + k] * b_op;
                // Arithmetic shift drops fraction bits, rounding toward minus infinity.
                assign prod_next[P] = full[FW-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg <= prod_next;
            for (int r = 0; r < ROWS; r++)
            begin
                trans_reg[r] <= cur[r * COLS + COLS - 1];
            end
        end
    end

    assign prod  = prod_reg;
    assign trans = trans_reg;

endmodule

>>> rtl/atu_sum_sat.sv
// Dot-product sums and saturation for compose and transform results.
module atu_sum_sat
    import atu_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic signed [COEF_BITS+((COEF_BITS > FIELD_W) ? COEF_BITS : FIELD_W)
                         -FRAC_BITS-1:0]          prod   [NUM_PROD],
    input  logic signed [COEF_BITS-1:0]           trans  [ROWS],
    output logic signed [COEF_BITS-1:0]           comp   [MAT_SIZE],
    output logic signed [FIELD_W-1:0]             pt_out [ROWS],
    output logic                                  clip
);

    localparam int BW  = (COEF_BITS > FIELD_W) ? COEF_BITS : FIELD_W;
    localparam int PSW = COEF_BITS + BW - FRAC_BITS;
    localparam int SW  = PSW + 2;

    localparam logic signed [SW-1:0] CMAX_S = SW'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] CMIN_S = ~CMAX_S;
    localparam logic signed [SW-1:0] PMAX_S = SW'((64'sd1 <<< (FIELD_W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] PMIN_S = ~PMAX_S;

    logic [ROWS-1:0] clip_row;

    function automatic logic signed [COEF_BITS-1:0] sat_coef(logic signed [SW-1:0] s);
        logic signed [SW-1:0] v;
        v = s;
        if (s > CMAX_S)
        begin
            v = CMAX_S;
        end
        else if (s < CMIN_S)
        begin
            v = CMIN_S;
        end
        return v[COEF_BITS-1:0];
    endfunction

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        logic signed [SW-1:0] sum_c [COLS];
        logic signed [SW-1:0] sum_t;

        for (genvar c = 0; c < COLS; c++)
        begin : g_col
            localparam int P = (r * COLS + c) * DOTS;
            logic signed [SW-1:0] terms;

            assign terms = SW'(prod[P]) + SW'(prod[P + 1]) + SW'(prod[P + 2]);
            // Translation column also carries the current translation.
            if (c == COLS - 1)
            begin : g_trans
                assign sum_c[c] = terms + SW'(trans[r]);
            end
            else
            begin : g_plain
                assign sum_c[c] = terms;
            end
            assign comp[r * COLS + c] = sat_coef(sum_c[c]);
        end

        assign sum_t = sum_c[0] + SW'(trans[r]);

        always_comb
        begin
            clip_row[r] = 1'b1;
            if (sum_t > PMAX_S)
            begin
                pt_out[r] = PMAX_S[FIELD_W-1:0];
            end
            else if (sum_t < PMIN_S)
            begin
                pt_out[r] = PMIN_S[FIELD_W-1:0];
            end
            else
            begin
                pt_out[r]   = sum_t[FIELD_W-1:0];
                clip_row[r] = 1'b0;
            end
        end
    end

    assign clip = |clip_row;

endmodule

>>> rtl/affine_transform_unit.sv
// Top level of the 3x4 affine matrix transform unit.
//
// Input stream (s_*): one command per transfer. s_tuser carries the command
// and the row select, s_tdata four row coefficients and a point, all signed
// Q16.16. Commands load a row of the current or operand matrix, compose
// (current = current x operand, current translation added), reset current
// to identity, or transform a point.
// Output stream (m_*): one transfer per transform command, carrying the
// three saturated coordinates and a flag that is set if any was clipped.
// Pipeline: input register, product register (36 parallel multipliers fed
// from the matrix registers), result register. A point passes the input,
// product and result registers; loads and identity finish in the input
// register. One command is taken per cycle while nothing stalls; the
// command after a compose waits until the composed matrix is written back.
// Reset sets both matrices to identity and empties the pipeline.
// When the receiver stalls, the result register and a transform behind it
// hold, and a compose or transform behind them drops s_tready until m_tready returns.
`include "assert_macros.svh"

module affine_transform_unit
    import atu_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // coef_0, coef_1, coef_2, coef_3, point_x, point_y, point_z (32 bits each)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command [2:0], row_select [4:3]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z (32 bits each)
    output logic [OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int BW  = (COEF_BITS > FIELD_W) ? COEF_BITS : FIELD_W;
    localparam int PSW = COEF_BITS + BW - FRAC_BITS;

    localparam logic signed [BW-1:0] LMAX = BW'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
    localparam logic signed [BW-1:0] LMIN = ~LMAX;

    // One in fixed point, or the largest coefficient where one does not fit.
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = (FRAC_BITS < COEF_BITS - 1)
        ? COEF_BITS'(64'sd1 <<< FRAC_BITS)
        : COEF_BITS'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);

    // Input stage
    logic                         a_valid_reg;
    cmd_t                         a_cmd_reg;
    logic [ROW_SEL_W-1:0]         a_row_reg;
    logic signed [FIELD_W-1:0]    a_coef_reg [COLS];
    logic signed [FIELD_W-1:0]    a_pt_reg   [ROWS];

    // Product stage control
    logic                         b_valid_reg;
    logic                         b_compose_reg;

    // Matrices
    logic signed [COEF_BITS-1:0]  cur_reg  [MAT_SIZE];
    logic signed [COEF_BITS-1:0]  cur_next [MAT_SIZE];
    logic signed [COEF_BITS-1:0]  opd_reg  [MAT_SIZE];
    logic signed [COEF_BITS-1:0]  opd_next [MAT_SIZE];

    // Result register
    logic                         out_valid_reg;
    logic signed [FIELD_W-1:0]    out_coord_reg [ROWS];
    logic                         out_sat_reg;

    logic signed [PSW-1:0]        prod   [NUM_PROD];
    logic signed [COEF_BITS-1:0]  trans  [ROWS];
    logic signed [COEF_BITS-1:0]  comp   [MAT_SIZE];
    logic signed [FIELD_W-1:0]    pt_out [ROWS];
    logic                         clip;

    logic                         s_fire;
    logic                         out_free;
    logic                         b_comp_busy;
    logic                         b_done;
    logic                         b_free;
    logic                         a_to_b;
    logic                         a_done;
    logic                         b_load;
    stage_ctl_t                   b_ctl;

    function automatic logic signed [COEF_BITS-1:0] ident_at(int r, int c);
        return (r == c) ? COEF_ONE : '0;
    endfunction

    // Widen a loaded coefficient and clip it to the storage range.
    function automatic logic signed [COEF_BITS-1:0] load_coef(logic signed [FIELD_W-1:0] v);
        logic signed [BW-1:0] e;
        e = BW'(v);
        if (e > LMAX)
        begin
            e = LMAX;
        end
        else if (e < LMIN)
        begin
            e = LMIN;
        end
        return e[COEF_BITS-1:0];
    endfunction

    // Handshake and stage advance
    assign out_free    = !out_valid_reg || m_tready;
    assign b_comp_busy = b_valid_reg && b_compose_reg;
    assign b_done      = b_valid_reg && (b_compose_reg || out_free);
    assign b_free      = !b_valid_reg || b_done;
    assign a_to_b      = (a_cmd_reg == CMD_COMPOSE) || (a_cmd_reg == CMD_TRANSFORM);
    // Hold every command behind a compose until current is written back.
    assign a_done      = a_valid_reg && !b_comp_busy && (!a_to_b || b_free);
    assign b_load      = a_done && a_to_b;
    assign s_tready    = !a_valid_reg || a_done;
    assign s_fire      = s_tvalid && s_tready;

    assign b_ctl.load    = b_load;
    assign b_ctl.compose = (a_cmd_reg == CMD_COMPOSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            b_compose_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_done)
            begin
                a_valid_reg <= 1'b0;
            end

            if (b_load)
            begin
                b_valid_reg   <= 1'b1;
                b_compose_reg <= b_ctl.compose;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_done && !b_compose_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the command payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_cmd_reg <= cmd_t'(s_tuser[CMD_W-1:0]);
            a_row_reg <= s_tuser[CMD_W+ROW_SEL_W-1:CMD_W];
            for (int c = 0; c < COLS; c++)
            begin
                a_coef_reg[c] <= s_tdata[c*FIELD_W +: FIELD_W];
            end
            for (int r = 0; r < ROWS; r++)
            begin
                a_pt_reg[r] <= s_tdata[(COLS+r)*FIELD_W +: FIELD_W];
            end
        end
    end

    // Matrix updates: row loads and identity from the input stage,
    // compose write-back from the product stage.
    always_comb
    begin
        cur_next = cur_reg;
        opd_next = opd_reg;
        if (b_done && b_compose_reg)
        begin
            cur_next = comp;
        end
        else if (a_done)
        begin
            unique case (a_cmd_reg)
                CMD_LOAD_CUR:
                begin
                    if (a_row_reg < ROW_SEL_W'(ROWS))
                    begin
                        for (int c = 0; c < COLS; c++)
                        begin
                            cur_next[{a_row_reg, 2'(c)}] = load_coef(a_coef_reg[c]);
                        end
                    end
                end
                CMD_LOAD_OPD:
                begin
                    if (a_row_reg < ROW_SEL_W'(ROWS))
                    begin
                        for (int c = 0; c < COLS; c++)
                        begin
                            opd_next[{a_row_reg, 2'(c)}] = load_coef(a_coef_reg[c]);
                        end
                    end
                end
                CMD_IDENTITY:
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        for (int c = 0; c < COLS; c++)
                        begin
                            cur_next[r * COLS + c] = ident_at(r, c);
                        end
                    end
                end
                default:
                begin
                    // Compose, transform and unknown codes leave the matrices alone here.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    cur_reg[r * COLS + c] <= ident_at(r, c);
                    opd_reg[r * COLS + c] <= ident_at(r, c);
                end
            end
        end
        else
        begin
            cur_reg <= cur_next;
            opd_reg <= opd_next;
        end
    end

    atu_product_stage #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_product (
        .clk   (clk),
        .ctl   (b_ctl),
        .cur   (cur_reg),
        .opd   (opd_reg),
        .point (a_pt_reg),
        .prod  (prod),
        .trans (trans)
    );

    atu_sum_sat #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .prod   (prod),
        .trans  (trans),
        .comp   (comp),
        .pt_out (pt_out),
        .clip   (clip)
    );

    // Result register: advance only when the slot is free.
    always_ff @(posedge clk)
    begin
        if (b_done && !b_compose_reg)
        begin
            out_coord_reg <= pt_out;
            out_sat_reg   <= clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_coord_reg[2], out_coord_reg[1], out_coord_reg[0]};
    assign m_tuser  = out_sat_reg;

    // A result only appears after a transform left the product stage.
    `ASSERT_PROP(a_result_source, clk, rst_n, $rose(out_valid_reg) |-> $past(b_done && !b_compose_reg))
    // A transform waiting on a stalled output stays in the product stage.
    `ASSERT_PROP(a_no_drop, clk, rst_n, (b_valid_reg && !b_compose_reg && !out_free) |=> b_valid_reg)
    // Nothing reaches the product stage while a compose is still in it.
    `ASSERT_NEVER(a_compose_hazard, clk, rst_n, b_load && b_comp_busy)
    // The operand matrix, checked at its first coefficient, changes only on an operand row load.
    `ASSERT_PROP(a_opd_hold, clk, rst_n, !(a_done && a_cmd_reg == CMD_LOAD_OPD) |=> $stable(opd_reg[0]))

endmodule
